// File: rtl/dtqs_pkg.sv
// types and constants shared by the dns tunnel query screen modules
`default_nettype none

package dtqs_pkg;

  localparam int ADDR_W        = 32;
  localparam int TIME_W        = 32;
  localparam int CNT_W         = 8;
  localparam int LEN_W         = 8;
  localparam int DLIM_W        = 4;
  localparam int CHUNK_BYTES_W = 4;
  localparam int HCOUNT_W      = 9;
  localparam int OUT_W         = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int PROD_W        = 13;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam int         DIGIT_SCALE = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_LIMIT = 2'd3;

  localparam logic [TIME_W-1:0] RST_EXPIRY      = 32'd60;
  localparam logic [CNT_W-1:0]  RST_COUNT_LIMIT = 8'd10;
  localparam logic [LEN_W-1:0]  RST_LEN_LIMIT   = 8'd32;
  localparam logic [DLIM_W-1:0] RST_DIGIT_LIMIT = 4'd5;

  typedef enum logic [2:0] {
    VERDICT_NEW     = 3'd0,
    VERDICT_EXPIRED = 3'd1,
    VERDICT_RATE    = 3'd2,
    VERDICT_DIGIT   = 3'd3,
    VERDICT_CLEAN   = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [CNT_W-1:0]  count_limit;
    logic [LEN_W-1:0]  length_limit;
    logic [DLIM_W-1:0] digit_limit;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] digits;
  } name_sum_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] created;
  } entry_t;

  // packed msb first, so verdict lands in the low bits
  typedef struct packed {
    logic [LEN_W-1:0]    name_length;
    logic [HCOUNT_W-1:0] host_count;
    verdict_t            verdict;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/dtqs_ram.sv
// generic single write port ram with registered read
`default_nettype none

module dtqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/dtqs_lane.sv
// one byte lane: flags an ascii digit in an enabled byte
`default_nettype none

module dtqs_lane (
  input  wire logic [7:0] byte_in,
  input  wire logic       en,
  output logic            is_digit
);

  import dtqs_pkg::*;

  assign is_digit = en && (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);

endmodule

`default_nettype wire

// File: rtl/dtqs_scan.sv
// byte lanes, digit merge and the running name length and digit counters
`default_nettype none

module dtqs_scan #(
  parameter int BYTES_PER_ITEM = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                accept,
  input  wire logic                                last,
  input  wire logic [8*BYTES_PER_ITEM-1:0]         chunk,
  input  wire logic [dtqs_pkg::CHUNK_BYTES_W-1:0]  chunk_bytes,
  output dtqs_pkg::name_sum_t                      total
);

  import dtqs_pkg::*;

  localparam logic [CHUNK_BYTES_W-1:0] MAX_BYTES = CHUNK_BYTES_W'(BYTES_PER_ITEM);

  logic [CHUNK_BYTES_W-1:0]  nb_eff;
  logic [BYTES_PER_ITEM-1:0] lane_dig;
  logic [CHUNK_BYTES_W-1:0]  dig_cnt;
  logic [LEN_W:0]            len_sum;
  logic [LEN_W:0]            dig_sum;
  logic [LEN_W-1:0]          run_len_r, run_len_nxt;
  logic [LEN_W-1:0]          run_dig_r, run_dig_nxt;

  assign nb_eff = (chunk_bytes > MAX_BYTES) ? MAX_BYTES : chunk_bytes;

  for (genvar i = 0; i < BYTES_PER_ITEM; i++) begin : g_lane
    dtqs_lane u_lane (
      .byte_in  (chunk[8*i +: 8]),
      .en       (CHUNK_BYTES_W'(i) < nb_eff),
      .is_digit (lane_dig[i])
    );
  end

  // merge: count the lanes that saw a digit
  always_comb begin
    dig_cnt = '0;
    for (int i = 0; i < BYTES_PER_ITEM; i++) begin
      dig_cnt = dig_cnt + CHUNK_BYTES_W'(lane_dig[i]);
    end
  end

  assign len_sum = {1'b0, run_len_r} + (LEN_W+1)'(nb_eff);
  assign dig_sum = {1'b0, run_dig_r} + (LEN_W+1)'(dig_cnt);

  assign total.length = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
  assign total.digits = dig_sum[LEN_W] ? {LEN_W{1'b1}} : dig_sum[LEN_W-1:0];

  always_comb begin
    run_len_nxt = run_len_r;
    run_dig_nxt = run_dig_r;
    if (accept) begin
      run_len_nxt = last ? '0 : total.length;
      run_dig_nxt = last ? '0 : total.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r <= '0;
      run_dig_r <= '0;
    end else begin
      run_len_r <= run_len_nxt;
      run_dig_r <= run_dig_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dtqs_table.sv
// per-host table: slot remainder, read-modify-write sequencer and result register
`default_nettype none

module dtqs_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dtqs_pkg::cfg_t                cfg,
  input  wire logic                          start,
  output logic                               ready,
  input  wire logic [dtqs_pkg::ADDR_W-1:0]   address,
  input  wire logic [dtqs_pkg::TIME_W-1:0]   now,
  input  wire dtqs_pkg::name_sum_t           sum,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dtqs_pkg::result_t                  result
);

  import dtqs_pkg::*;

  localparam int SLOT_W    = $clog2(TABLE_ENTRIES);
  localparam int PROD_BITS = 2 * ADDR_W + 1;
  // table size reciprocal, rounded up and scaled by 2^(ADDR_W + SLOT_W)
  localparam logic [PROD_BITS-1:0] RECIP_FULL =
    ((PROD_BITS'(1) << (ADDR_W + SLOT_W)) + PROD_BITS'(TABLE_ENTRIES) - PROD_BITS'(1))
    / PROD_BITS'(TABLE_ENTRIES);
  localparam logic [ADDR_W:0]     RECIP     = RECIP_FULL[ADDR_W:0];
  localparam logic [SLOT_W-1:0]   SIZE_LO   = SLOT_W'(TABLE_ENTRIES);
  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_QUOT  = 7'b0000100,
    ST_MOD   = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_EVAL  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]      clr_r, clr_nxt;
  logic [SLOT_W-1:0]      rem_r, rem_nxt;
  logic [PROD_BITS-1:0]   quot_prod;
  logic [SLOT_W-1:0]      quot_lo_r;
  logic [2*SLOT_W-1:0]    quot_x_size;
  logic [ADDR_W-1:0]      addr_r;
  logic [TIME_W-1:0]      now_r;
  logic [LEN_W-1:0]       len_r;
  logic [LEN_W-1:0]       dig_r;
  logic                   miss_r, expired_r, rate_r, digit_r;
  logic [HCOUNT_W-1:0]    cnt_inc_r;
  logic                   out_valid_r, out_valid_nxt;
  result_t                result_r, result_nxt;

  entry_t                 rd;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                 wr_entry;
  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [$bits(entry_t)-1:0] ram_wdata;

  logic                   hit;
  logic [TIME_W-1:0]      age;
  logic [HCOUNT_W-1:0]    cnt_inc;
  logic [PROD_W-1:0]      dig_x10;
  logic [PROD_W-1:0]      need;
  logic                   digit_flag;
  logic                   out_free;
  logic                   commit;

  assign ready    = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_DONE) && out_free;

  // quotient by the table size through a constant multiply; only its low
  // bits matter, since the remainder fits in the slot index
  assign quot_prod   = PROD_BITS'(addr_r) * PROD_BITS'(RECIP);
  assign quot_x_size = (2*SLOT_W)'(quot_lo_r) * (2*SLOT_W)'(SIZE_LO);

  assign rd = entry_t'(ram_rdata);

  // lookup checks on the read entry
  assign hit        = rd.valid && (rd.address == addr_r);
  assign age        = now_r - rd.created;
  assign cnt_inc    = {1'b0, rd.count} + HCOUNT_W'(1);
  assign dig_x10    = PROD_W'(dig_r) * PROD_W'(DIGIT_SCALE);
  assign need       = (PROD_W'(cfg.digit_limit) + PROD_W'(1)) * PROD_W'(len_r);
  assign digit_flag = (len_r > cfg.length_limit) && (dig_x10 >= need);

  always_comb begin
    wr_entry   = rd;
    result_nxt = result_r;
    result_nxt.name_length = len_r;
    if (miss_r) begin
      wr_entry.valid   = 1'b1;
      wr_entry.address = addr_r;
      wr_entry.count   = CNT_W'(1);
      wr_entry.created = now_r;
      result_nxt.verdict    = VERDICT_NEW;
      result_nxt.host_count = HCOUNT_W'(1);
    end else if (expired_r) begin
      wr_entry.valid = 1'b0;
      result_nxt.verdict    = VERDICT_EXPIRED;
      result_nxt.host_count = '0;
    end else if (rate_r) begin
      wr_entry.valid = 1'b0;
      result_nxt.verdict    = VERDICT_RATE;
      result_nxt.host_count = '0;
    end else begin
      wr_entry.count = cnt_inc_r[CNT_W-1:0];
      result_nxt.verdict    = digit_r ? VERDICT_DIGIT : VERDICT_CLEAN;
      result_nxt.host_count = cnt_inc_r;
    end
  end

  assign ram_we    = (state_r == ST_CLEAR) || commit;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : rem_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : wr_entry;

  dtqs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state_r == ST_READ),
    .raddr (rem_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    rem_nxt   = rem_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + SLOT_W'(1);
        if (clr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_QUOT;
        end
      end
      ST_QUOT: state_nxt = ST_MOD;
      ST_MOD: begin
        rem_nxt   = addr_r[SLOT_W-1:0] - quot_x_size[SLOT_W-1:0];
        state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (ready && start) begin
      addr_r <= address;
      now_r  <= now;
      len_r  <= sum.length;
      dig_r  <= sum.digits;
    end
    if (state_r == ST_QUOT) begin
      quot_lo_r <= quot_prod[ADDR_W+SLOT_W +: SLOT_W];
    end
    if (state_r == ST_EVAL) begin
      miss_r    <= !hit;
      expired_r <= age > cfg.expiry;
      rate_r    <= cnt_inc > {1'b0, cfg.count_limit};
      digit_r   <= digit_flag;
      cnt_inc_r <= cnt_inc;
    end
    if (commit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

// File: rtl/dns_tunnel_query_screen_top.sv
// dns tunnel query screen: per-host query rate and digit-share screen
//
// in_*: one transaction carries up to BYTES_PER_ITEM query-name bytes plus the
// source address and time; in_tlast marks the final chunk of a name.
// out_*: one verdict transaction per name, raised after its last chunk.
// cfg_*: register writes, taken on any cycle with cfg_we high; write only idle.
// a chunk that is not last is taken whenever in_tready is high, so such chunks
// stream at one per cycle while no table pass holds in_tready low. a last chunk
// starts a table pass through the slot quotient (constant reciprocal multiply),
// the slot remainder, the ram read, the compare and the write/result states, so
// the verdict turns valid as in_tready returns; the ram read port and this
// sequencer hold one name in flight.
// the verdict sits in an output register: while it waits, chunks that are
// not last are still taken; the next table pass waits in its final cycle
// until out_tready frees the register.
// after reset the table is cleared, one entry per cycle, with in_tready low
// until the last entry is cleared; state, cfg and counters take their reset values.
`default_nettype none

module dns_tunnel_query_screen_top #(
  parameter int TABLE_ENTRIES  = 64,
  parameter int BYTES_PER_ITEM = 8,
  localparam int IN_W = ((dtqs_pkg::ADDR_W + dtqs_pkg::TIME_W + 8*BYTES_PER_ITEM
                          + dtqs_pkg::CHUNK_BYTES_W + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // source_address, now_seconds, name_chunk, chunk_bytes, zero pad
  input  wire logic [IN_W-1:0]                  in_tdata,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // verdict, host_count, name_length, zero pad
  output logic [dtqs_pkg::OUT_W-1:0]            out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [dtqs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dtqs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import dtqs_pkg::*;

  localparam int CHUNK_W   = 8 * BYTES_PER_ITEM;
  localparam int NOW_LSB   = ADDR_W;
  localparam int CHUNK_LSB = ADDR_W + TIME_W;
  localparam int NB_LSB    = CHUNK_LSB + CHUNK_W;

  cfg_t       cfg_r, cfg_nxt;
  name_sum_t  name_sum;
  result_t    res;
  logic       in_acc;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_EXPIRY:      cfg_nxt.expiry       = cfg_wdata[TIME_W-1:0];
        CFG_COUNT_LIMIT: cfg_nxt.count_limit  = cfg_wdata[CNT_W-1:0];
        CFG_LEN_LIMIT:   cfg_nxt.length_limit = cfg_wdata[LEN_W-1:0];
        CFG_DIGIT_LIMIT: cfg_nxt.digit_limit  = cfg_wdata[DLIM_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expiry       <= RST_EXPIRY;
      cfg_r.count_limit  <= RST_COUNT_LIMIT;
      cfg_r.length_limit <= RST_LEN_LIMIT;
      cfg_r.digit_limit  <= RST_DIGIT_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dtqs_scan #(
    .BYTES_PER_ITEM (BYTES_PER_ITEM)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .last        (in_tlast),
    .chunk       (in_tdata[CHUNK_LSB +: CHUNK_W]),
    .chunk_bytes (in_tdata[NB_LSB +: CHUNK_BYTES_W]),
    .total       (name_sum)
  );

  dtqs_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_tvalid && in_tlast),
    .ready     (in_tready),
    .address   (in_tdata[ADDR_W-1:0]),
    .now       (in_tdata[NOW_LSB +: TIME_W]),
    .sum       (name_sum),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (res)
  );

  assign out_tdata = {(OUT_W - $bits(result_t))'(0), res};

endmodule

`default_nettype wire

// File: rtl/dtqs_checker.sv
// port-level checks for the dns tunnel query screen, bound to the top level
`default_nettype none

module dtqs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        in_tlast,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [dtqs_pkg::OUT_W-1:0]  out_tdata
);

  import dtqs_pkg::*;

  result_t r;
  assign r = result_t'(out_tdata[$bits(result_t)-1:0]);

  // reset leaves no verdict pending
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("verdict valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled verdict changed");

  // a last chunk starts a table pass that blocks the input
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input ready during table pass");

  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (r.verdict == VERDICT_NEW) |-> r.host_count == HCOUNT_W'(1))
    else $error("new host count not one");

  a_removed_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (r.verdict == VERDICT_EXPIRED || r.verdict == VERDICT_RATE)
    |-> r.host_count == '0)
    else $error("removed host count not zero");

endmodule

bind dns_tunnel_query_screen_top dtqs_checker u_dtqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: test/dns_tunnel_query_screen_top_tb.sv
// testbench for the dns tunnel query screen: random name streams checked against a host-table predictor
`default_nettype none

module dns_tunnel_query_screen_top_tb;
  import dtqs_pkg::*;

  localparam int SLOTS       = 64;
  localparam int CHUNK_W     = 64;
  localparam int FIELDS_W    = ADDR_W + TIME_W + CHUNK_W + CHUNK_BYTES_W;
  localparam int IN_W        = ((FIELDS_W + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 4000;
  // give a table pass some margin to finish
  localparam int SETTLE      = 16;

  class screen_scoreboard;
    logic [TIME_W-1:0] expiry;
    logic [CNT_W-1:0]  count_limit;
    logic [LEN_W-1:0]  length_limit;
    logic [DLIM_W-1:0] digit_limit;
    bit                slot_valid[SLOTS];
    logic [ADDR_W-1:0] slot_addr[SLOTS];
    int unsigned       slot_count[SLOTS];
    logic [TIME_W-1:0] slot_created[SLOTS];
    int unsigned       name_len;
    int unsigned       name_digits;
    result_t           verdicts[$];
    int                errors;

    function new();
      expiry       = RST_EXPIRY;
      count_limit  = RST_COUNT_LIMIT;
      length_limit = RST_LEN_LIMIT;
      digit_limit  = RST_DIGIT_LIMIT;
      foreach (slot_valid[i]) begin
        slot_valid[i]   = 1'b0;
        slot_addr[i]    = '0;
        slot_count[i]   = 0;
        slot_created[i] = '0;
      end
      name_len    = 0;
      name_digits = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_EXPIRY:      expiry = v;
        CFG_COUNT_LIMIT: count_limit = v[CNT_W-1:0];
        CFG_LEN_LIMIT:   length_limit = v[LEN_W-1:0];
        CFG_DIGIT_LIMIT: digit_limit = v[DLIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void note_chunk(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now,
                             logic [CHUNK_W-1:0] chunk,
                             logic [CHUNK_BYTES_W-1:0] nbytes, bit last);
      int unsigned n, dig, len, digs, slot, bumped, share_bound;
      logic [TIME_W-1:0] age;
      result_t r;
      n = (nbytes > 8) ? 8 : nbytes;
      dig = 0;
      for (int i = 0; i < n; i++) begin
        if (chunk[8*i +: 8] >= CHAR_ZERO && chunk[8*i +: 8] <= CHAR_NINE) dig++;
      end
      name_len    = (name_len + n > 255) ? 255 : name_len + n;
      name_digits = (name_digits + dig > 255) ? 255 : name_digits + dig;
      if (!last) return;
      len         = name_len;
      digs        = name_digits;
      name_len    = 0;
      name_digits = 0;

      slot = addr % SLOTS;
      age  = now - slot_created[slot];
      if (!slot_valid[slot] || slot_addr[slot] != addr) begin
        // miss: a different host in the slot is simply replaced
        slot_valid[slot]   = 1'b1;
        slot_addr[slot]    = addr;
        slot_count[slot]   = 1;
        slot_created[slot] = now;
        r.verdict    = VERDICT_NEW;
        r.host_count = 9'd1;
      end else if (age > expiry) begin
        slot_valid[slot] = 1'b0;
        r.verdict    = VERDICT_EXPIRED;
        r.host_count = '0;
      end else begin
        bumped = slot_count[slot] + 1;
        if (bumped > count_limit) begin
          slot_valid[slot] = 1'b0;
          r.verdict    = VERDICT_RATE;
          r.host_count = '0;
        end else begin
          slot_count[slot] = bumped;
          r.host_count     = 9'(bumped);
          share_bound = (digit_limit + 1) * len;
          if (len > length_limit && digs * DIGIT_SCALE >= share_bound)
            r.verdict = VERDICT_DIGIT;
          else
            r.verdict = VERDICT_CLEAN;
        end
      end
      r.name_length = len[LEN_W-1:0];
      verdicts.push_back(r);
    endfunction

    // out_tdata: verdict [2:0], host_count [11:3], name_length [19:12], pad
    function void check_verdict(logic [OUT_W-1:0] d);
      result_t want;
      if (verdicts.size() == 0) begin
        $error("verdict 0x%0h arrived with no name pending", d);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (d[2:0] !== want.verdict) begin
        $error("verdict expected %0d got %0d", want.verdict, d[2:0]);
        errors++;
      end
      if (d[11:3] !== want.host_count) begin
        $error("host_count expected %0d got %0d", want.host_count, d[11:3]);
        errors++;
      end
      if (d[19:12] !== want.name_length) begin
        $error("name_length expected %0d got %0d", want.name_length, d[19:12]);
        errors++;
      end
      if (d[OUT_W-1:20] !== '0) begin
        $error("pad expected 0 got %0h", d[OUT_W-1:20]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_EXPIRY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  screen_scoreboard sb = new();
  int               snd_idle_pct = 0;
  int               rcv_idle_pct = 0;
  int               sent_items = 0;
  int               quiet_cycles = 0;
  logic [TIME_W-1:0] now_t = 32'd1000;
  logic [ADDR_W-1:0] hosts[8];

  dns_tunnel_query_screen_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
    out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic offer_chunk(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now,
                             logic [CHUNK_W-1:0] chunk,
                             logic [CHUNK_BYTES_W-1:0] nbytes, bit last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - FIELDS_W){1'b0}}, nbytes, chunk, now, addr};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_chunk(addr, now, chunk, nbytes, last);
    sent_items++;
  endtask

  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_settings(logic [31:0] exp_s, int cnt_lim, int len_lim, int dig_lim);
    write_reg(CFG_EXPIRY, exp_s);
    write_reg(CFG_COUNT_LIMIT, 32'(cnt_lim));
    write_reg(CFG_LEN_LIMIT, 32'(len_lim));
    write_reg(CFG_DIGIT_LIMIT, 32'(dig_lim));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(int digit_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < digit_pct) return CHAR_ZERO + 8'($urandom_range(0, 9));
    r = $urandom_range(0, 9);
    // '/' and ':' sit right outside the digit range
    case (r)
      0: return CHAR_ZERO - 8'd1;
      1: return CHAR_NINE + 8'd1;
      2, 3, 4, 5: return 8'($urandom);
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // six hosts on neighboring slots, two more aliasing the first two slots
  task automatic pick_hosts();
    int base;
    base = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < 8; i++)
      hosts[i] = ($urandom & 32'hFFFF_FFC0) | 32'((base + i % 6) % SLOTS);
  endtask

  task automatic send_name(logic [ADDR_W-1:0] addr, int n_chunks, int digit_pct);
    logic [CHUNK_W-1:0] chunk;
    logic [CHUNK_BYTES_W-1:0] nbytes;
    bit last;
    int r;
    for (int k = 0; k < n_chunks; k++) begin
      for (int b = 0; b < 8; b++) chunk[8*b +: 8] = pick_byte(digit_pct);
      last = (k == n_chunks - 1);
      r = $urandom_range(0, 99);
      if (r < 4) nbytes = '0;
      else if (r < 8) nbytes = 4'($urandom_range(9, 15));
      else if (last || r < 30) nbytes = 4'($urandom_range(1, 8));
      else nbytes = 4'd8;
      // address and time only matter on the last chunk
      if (last) offer_chunk(addr, now_t, chunk, nbytes, 1'b1);
      else offer_chunk($urandom, $urandom, chunk, nbytes, 1'b0);
    end
  endtask

  task automatic random_names(int n_items, int n_hosts, int max_chunks);
    int stop_at, n, r, pct;
    logic [ADDR_W-1:0] addr;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (max_chunks > 1 && r < 3) begin
        // long digit-heavy names push both counters into saturation
        n   = $urandom_range(33, 40);
        pct = $urandom_range(85, 100);
      end else begin
        n   = $urandom_range(1, max_chunks);
        pct = $urandom_range(0, 100);
      end
      if ($urandom_range(0, 99) < 5) addr = $urandom;
      else addr = hosts[$urandom_range(0, n_hosts - 1)];
      r = $urandom_range(0, 99);
      if (r >= 70 && r < 95) now_t += $urandom_range(1, 3);
      else if (r >= 95 && r < 98) now_t += sb.expiry + $urandom_range(0, 2);
      else if (r >= 98) now_t = $urandom;
      send_name(addr, n, pct);
      if ($urandom_range(0, 199) == 0) settle_idle();
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] host_a;
    host_a = 32'h0A00_0105;
    snd_idle_pct = 6;
    rcv_idle_pct = 50;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // table clearing pass holds in_tready low
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    offer_chunk(host_a, 32'd100, 64'h3837_3635_3433_3231, 4'd8, 1'b1);
    offer_chunk(host_a, 32'd0, 64'h3939_3939_3939_3939, 4'd0, 1'b0);
    offer_chunk(host_a, 32'd0, 64'h3A39_302F_3A39_302F, 4'd8, 1'b0);
    offer_chunk(host_a, 32'd0, 64'h3535_3535_3535_3535, 4'd15, 1'b0);
    offer_chunk(host_a, 32'd110, 64'h0, 4'd9, 1'b1);
    for (int k = 0; k < 5; k++)
      offer_chunk(host_a, 32'd160, 64'h3736_3534_3332_3130, 4'd8, k == 4);
    offer_chunk(host_a, 32'd161, 64'h6463_6261_6463_6261, 4'd4, 1'b1);
    offer_chunk(host_a + 32'd64, 32'd200, 64'h6161_6161_6161_6161, 4'd8, 1'b1);
    offer_chunk(host_a, 32'd200, 64'h6161_6161_6161_6161, 4'd8, 1'b1);
    offer_chunk(host_a + 32'd64, 32'd201, 64'h6161_6161_6161_6161, 4'd3, 1'b1);
    offer_chunk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    offer_chunk(32'hFFFF_FFFF, 32'd5, 64'h0, 4'd1, 1'b1);
    offer_chunk(32'h0, 32'h0, 64'h0, 4'd8, 1'b1);
    offer_chunk(32'h0, 32'h0, 64'h0, 4'd8, 1'b1);

    settle_idle();
    apply_settings(RST_EXPIRY, RST_COUNT_LIMIT, RST_LEN_LIMIT, RST_DIGIT_LIMIT);
    pick_hosts();
    random_names(250, 8, 6);

    settle_idle();
    apply_settings(32'd0, 0, 0, 0);
    pick_hosts();
    random_names(200, 8, 6);

    // one host, short names: the count climbs to the limit of 255, where the next name is a rate hit
    settle_idle();
    apply_settings(32'hFFFF_FFFF, 255, 255, 10);
    pick_hosts();
    random_names(330, 1, 1);

    snd_idle_pct = 50;
    rcv_idle_pct = 6;
    settle_idle();
    apply_settings(32'd5, 3, 8, 2);
    pick_hosts();
    random_names(250, 8, 6);

    settle_idle();
    apply_settings($urandom_range(0, 200), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 15));
    pick_hosts();
    random_names(200, 8, 8);

    settle_idle();
    apply_settings(32'd100, 20, 16, 15);
    pick_hosts();
    random_names(200, 8, 6);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    settle_idle();
    apply_settings($urandom_range(0, 200), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 10));
    pick_hosts();
    random_names(250, 8, 6);

    settle_idle();
    apply_settings(32'd30, 10, 32, 5);
    pick_hosts();
    random_names(250, 8, 6);

    settle_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
